>>> sv/keyed_max_aggregation_table_defines.svh
// Assertion macros shared by the keyed max aggregation table RTL.
`ifndef KEYED_MAX_AGGREGATION_TABLE_DEFINES_SVH
`define KEYED_MAX_AGGREGATION_TABLE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define KMAT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define KMAT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/kmat_pkg.sv
// Types and state codes shared by the keyed max aggregation table modules.
`timescale 1ns / 1ps
package kmat_pkg;

  localparam int unsigned KEY_W    = 16;
  localparam int unsigned FACTOR_W = 32;
  localparam int unsigned DEGREE_W = 3;
  localparam int unsigned NORMS_W  = 64;
  localparam int unsigned LANE_W   = 16;
  localparam int unsigned LANES    = NORMS_W / LANE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EMIT
  } kmat_state_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key_a;
    logic [KEY_W-1:0]    key_b;
    logic [FACTOR_W-1:0] factor;
    logic                has_degree;
    logic                has_norms;
    logic [DEGREE_W-1:0] degree;
    logic [NORMS_W-1:0]  norms_lo;
    logic [NORMS_W-1:0]  norms_hi;
  } kmat_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [FACTOR_W-1:0] factor;
    logic [DEGREE_W-1:0] degree;
    logic [NORMS_W-1:0]  norms_lo;
    logic [NORMS_W-1:0]  norms_hi;
  } kmat_entry_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic merge;
    logic sel_b;
  } kmat_cell_op_t;

endpackage

>>> sv/kmat_cell.sv
// One table cell: holds an entry, compares keys, merges, loads or takes its neighbor's entry.
`timescale 1ns / 1ps
module kmat_cell (
  input  logic                  clk,
  input  kmat_pkg::kmat_item_t  item,
  input  kmat_pkg::kmat_cell_op_t op,
  input  logic                  occupied,
  input  kmat_pkg::kmat_entry_t nbr,
  output kmat_pkg::kmat_entry_t entry,
  output logic                  match_a,
  output logic                  match_b
);
  import kmat_pkg::*;

  kmat_entry_t entry_r;
  kmat_entry_t entry_nxt;

  function automatic logic [NORMS_W-1:0] lane_max(input logic [NORMS_W-1:0] a,
                                                 input logic [NORMS_W-1:0] b);
    logic [NORMS_W-1:0] r;
    r = '0;
    for (int unsigned l = 0; l < LANES; l++) begin
      if (a[l*LANE_W +: LANE_W] > b[l*LANE_W +: LANE_W]) begin
        r[l*LANE_W +: LANE_W] = a[l*LANE_W +: LANE_W];
      end else begin
        r[l*LANE_W +: LANE_W] = b[l*LANE_W +: LANE_W];
      end
    end
    return r;
  endfunction

  assign match_a = occupied && (entry_r.key == item.key_a);
  assign match_b = occupied && (entry_r.key == item.key_b);
  assign entry   = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (op.shift) begin
      entry_nxt = nbr;
    end else if (op.load) begin
      entry_nxt.key      = op.sel_b ? item.key_b : item.key_a;
      entry_nxt.factor   = item.factor;
      entry_nxt.degree   = item.has_degree ? item.degree : '0;
      entry_nxt.norms_lo = item.has_norms ? item.norms_lo : '0;
      entry_nxt.norms_hi = item.has_norms ? item.norms_hi : '0;
    end else if (op.merge) begin
      if (item.factor > entry_r.factor) begin
        entry_nxt.factor = item.factor;
      end
      if (item.has_degree) begin
        if (item.degree > entry_r.degree) begin
          entry_nxt.degree = item.degree;
        end
        if (item.has_norms) begin
          entry_nxt.norms_lo = lane_max(entry_r.norms_lo, item.norms_lo);
          entry_nxt.norms_hi = lane_max(entry_r.norms_hi, item.norms_hi);
        end
      end
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> sv/keyed_max_aggregation_table.sv
// Top level: row of key cells, lookup and append control, and finish readout.
// Distribution word: the accept edge registers the item, then all cells compare and update in ST_MERGE.
// Finish word: one result per entry; entries shift one per cycle out of cell 0.
// Finish on an empty or overflowed table: one result.
// Results are strobed for one cycle, starting the cycle after the first readout edge.
// Reset clears the entry count, the overflow flag, the result strobe and the control state; cell contents stay.
`timescale 1ns / 1ps
`include "keyed_max_aggregation_table_defines.svh"
module keyed_max_aggregation_table #(
  parameter int unsigned MAX_GROUPS = 64,
  parameter int unsigned NORM_TERMS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [15:0] in_group_a,
  input  logic [15:0] in_group_b,
  input  logic [31:0] in_cs_factor,
  input  logic        in_has_degree,
  input  logic        in_has_norms,
  input  logic [2:0]  in_degree,
  input  logic [63:0] in_norms_lo,
  input  logic [63:0] in_norms_hi,
  output logic        out_strobe,
  output logic        out_entry_valid,
  output logic [15:0] out_group_key,
  output logic [31:0] out_max_factor,
  output logic [2:0]  out_max_degree_out,
  output logic [63:0] out_max_norms_lo_out,
  output logic [63:0] out_max_norms_hi_out,
  output logic        out_overflow_error,
  output logic        out_last
);
  import kmat_pkg::*;

  localparam int unsigned CW = $clog2(MAX_GROUPS + 1);

  function automatic logic [NORMS_W-1:0] lane_mask(input int unsigned first);
    logic [NORMS_W-1:0] m;
    m = '0;
    for (int unsigned l = 0; l < LANES; l++) begin
      if (first + l < NORM_TERMS) begin
        m[l*LANE_W +: LANE_W] = '1;
      end
    end
    return m;
  endfunction

  localparam logic [NORMS_W-1:0] MASK_LO = lane_mask(0);
  localparam logic [NORMS_W-1:0] MASK_HI = lane_mask(LANES);

  kmat_state_t state_r, state_nxt;
  kmat_item_t  item_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;

  logic accept;
  logic mrg_en, emit_en, single, shift_en;

  logic        out_strobe_r, out_strobe_nxt;
  kmat_entry_t out_entry_r, out_entry_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_ovf_r, out_ovf_nxt;
  logic        out_last_r, out_last_nxt;

  kmat_entry_t   entry_q [MAX_GROUPS];
  kmat_entry_t   nbr_q   [MAX_GROUPS];
  kmat_cell_op_t op_q    [MAX_GROUPS];
  logic [MAX_GROUPS-1:0] match_a, match_b;

  logic          hit_a, hit_b, do_b;
  logic          append_a, append_b, full_a, full_b;
  logic          load_a, load_b;
  logic [CW-1:0] cnt_a;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mrg_en    = 1'b0;
    emit_en   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = in_req_type ? ST_EMIT : ST_MERGE;
        end
      end
      ST_MERGE: begin
        mrg_en    = !ovf_r;
        state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        emit_en = 1'b1;
        if (ovf_r || cnt_r <= CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.key_a      <= in_group_a;
      item_r.key_b      <= in_group_b;
      item_r.factor     <= in_cs_factor;
      item_r.has_degree <= in_has_degree;
      item_r.has_norms  <= in_has_norms;
      item_r.degree     <= in_degree;
      item_r.norms_lo   <= in_norms_lo & MASK_LO;
      item_r.norms_hi   <= in_norms_hi & MASK_HI;
    end
  end

  // lookup against the table as it stood before the word
  assign hit_a    = |match_a;
  assign hit_b    = |match_b;
  assign do_b     = (item_r.key_b != item_r.key_a);
  assign append_a = !hit_a;
  assign full_a   = append_a && (cnt_r == CW'(MAX_GROUPS));
  assign load_a   = mrg_en && append_a && !full_a;
  assign cnt_a    = cnt_r + CW'(load_a);
  assign append_b = do_b && !hit_b;
  assign full_b   = append_b && !full_a && (cnt_a == CW'(MAX_GROUPS));
  assign load_b   = mrg_en && append_b && !full_a && !full_b;

  assign single   = ovf_r || (cnt_r == '0);
  assign shift_en = emit_en && !single;

  for (genvar i = 0; i < MAX_GROUPS; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic ld_a, ld_b, mg_a, mg_b;

    assign ld_a = load_a && (cnt_r == IDX);
    assign ld_b = load_b && (cnt_a == IDX);
    assign mg_a = mrg_en && match_a[i];
    assign mg_b = mrg_en && do_b && !full_a && match_b[i];

    assign op_q[i].shift = shift_en;
    assign op_q[i].load  = ld_a || ld_b;
    assign op_q[i].merge = mg_a || mg_b;
    assign op_q[i].sel_b = ld_b || mg_b;

    if (i == MAX_GROUPS - 1) begin : g_tail
      assign nbr_q[i] = entry_q[i];
    end else begin : g_link
      assign nbr_q[i] = entry_q[i+1];
    end

    kmat_cell u_cell (
      .clk      (clk),
      .item     (item_r),
      .op       (op_q[i]),
      .occupied (IDX < cnt_r),
      .nbr      (nbr_q[i]),
      .entry    (entry_q[i]),
      .match_a  (match_a[i]),
      .match_b  (match_b[i])
    );
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    out_strobe_nxt = emit_en;
    out_entry_nxt  = entry_q[0];
    out_valid_nxt  = 1'b1;
    out_ovf_nxt    = 1'b0;
    out_last_nxt   = (cnt_r == CW'(1));
    priority if (emit_en) begin
      cnt_nxt = single ? '0 : cnt_r - CW'(1);
      ovf_nxt = 1'b0;
      if (single) begin
        out_entry_nxt = '0;
        out_valid_nxt = 1'b0;
        out_ovf_nxt   = ovf_r;
        out_last_nxt  = 1'b1;
      end
    end else if (mrg_en) begin
      cnt_nxt = cnt_r + CW'(load_a) + CW'(load_b);
      ovf_nxt = full_a || full_b;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      out_entry_r <= out_entry_nxt;
      out_valid_r <= out_valid_nxt;
      out_ovf_r   <= out_ovf_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_strobe           = out_strobe_r;
  assign out_entry_valid      = out_valid_r;
  assign out_group_key        = out_entry_r.key;
  assign out_max_factor       = out_entry_r.factor;
  assign out_max_degree_out   = out_entry_r.degree;
  assign out_max_norms_lo_out = out_entry_r.norms_lo;
  assign out_max_norms_hi_out = out_entry_r.norms_hi;
  assign out_overflow_error   = out_ovf_r;
  assign out_last             = out_last_r;

  `KMAT_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CW'(MAX_GROUPS), "entry count above table size")
  `KMAT_ASSERT_ALWAYS(a_match_a_unique, clk, rst_n, $onehot0(match_a), "key a matches several cells")
  `KMAT_ASSERT_IMPLY(a_ovf_full, clk, rst_n, ovf_r, cnt_r == CW'(MAX_GROUPS), "overflow with room left")
  `KMAT_ASSERT_IMPLY(a_keys_disjoint, clk, rst_n, do_b, (match_a & match_b) == '0, "both keys hit one cell")
  `KMAT_ASSERT_IMPLY(a_last_clears, clk, rst_n, out_strobe_r && out_last_r, cnt_r == '0 && !ovf_r, "table not cleared after finish")

endmodule
